FILE: hdl/osd_pkg.sv
package osd_pkg;

    // pulse classes
    localparam logic [1:0] CLASS_SWEEP = 2'd0;
    localparam logic [1:0] CLASS_SYNC  = 2'd1;
    localparam logic [1:0] CLASS_SKIP  = 2'd2;

    // configuration register indexes
    localparam logic [7:0] REG_CAL_ENABLE  = 8'd0;
    localparam logic [7:0] REG_SWEEP_LIMIT = 8'd1;
    localparam logic [7:0] REG_SKIP_LIMIT  = 8'd2;
    localparam logic [7:0] REG_SYNC_BATCH  = 8'd3;

    // configuration reset values
    localparam logic [15:0] SWEEP_LIMIT_RST = 16'd500;
    localparam logic [15:0] SKIP_LIMIT_RST  = 16'd990;
    localparam logic [7:0]  SYNC_BATCH_RST  = 8'd10;

    // station phases
    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_A    = 2'd1;
    localparam logic [1:0] PHASE_B    = 2'd2;

    // sync width bands for axis selection
    localparam logic [31:0] BAND_LOW = 32'd500;
    localparam logic [31:0] BAND_1   = 32'd675;
    localparam logic [31:0] BAND_2   = 32'd781;
    localparam logic [31:0] BAND_3   = 32'd885;
    localparam logic [31:0] BAND_4   = 32'd989;
    localparam logic [31:0] BAND_5   = 32'd1083;
    localparam logic [31:0] BAND_6   = 32'd1200;
    localparam logic [31:0] BAND_7   = 32'd1300;
    localparam logic [31:0] BAND_8   = 32'd1400;

    typedef struct packed {
        logic        light_level;
        logic [31:0] tick_time;
    } sample_t;

    typedef struct packed {
        logic        pulse_done;
        logic [1:0]  pulse_class;
        logic        axis_is_x;
        logic [31:0] station_a_x;
        logic [31:0] station_a_y;
        logic [31:0] station_b_x;
        logic [31:0] station_b_y;
        logic        cal_trigger;
        logic [31:0] batch_span;
        logic [31:0] cal_total;
    } result_t;

    typedef struct packed {
        logic        cal_enable;
        logic [15:0] sweep_limit;
        logic [15:0] skip_limit;
        logic [7:0]  sync_batch;
    } cfg_t;

    // classified pulse event handed from front to back
    typedef struct packed {
        logic        done;
        logic [1:0]  cls;
        logic        counted;
        logic        axis_hit;
        logic        axis_val;
        logic [31:0] start;
    } evt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: hdl/osd_front.sv
module osd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  osd_pkg::sample_t  sample,
    input  osd_pkg::cfg_t     cfg,
    output osd_pkg::evt_t     evt
);

    logic        prev_level_reg;
    logic        prev_level_next;
    logic        pulse_open_reg;
    logic        pulse_open_next;
    logic [31:0] pulse_start_reg;
    logic [31:0] pulse_start_next;
    logic [31:0] width;
    logic        rise;
    logic        fall;

    // edge detection and pulse width
    assign rise  = !prev_level_reg && sample.light_level;
    assign fall  = prev_level_reg && !sample.light_level && pulse_open_reg;
    assign width = sample.tick_time - pulse_start_reg;

    always_comb
    begin
        prev_level_next  = prev_level_reg;
        pulse_open_next  = pulse_open_reg;
        pulse_start_next = pulse_start_reg;
        if (accept)
        begin
            prev_level_next = sample.light_level;
            if (rise && !pulse_open_reg)
            begin
                pulse_open_next  = 1'b1;
                pulse_start_next = sample.tick_time;
            end
            else if (fall)
            begin
                pulse_open_next = 1'b0;
            end
        end
    end

    // classify width and pick axis band
    always_comb
    begin
        evt.done     = fall;
        evt.start    = pulse_start_reg;
        evt.cls      = osd_pkg::CLASS_SWEEP;
        evt.counted  = 1'b0;
        evt.axis_hit = 1'b1;
        evt.axis_val = 1'b0;
        if (fall)
        begin
            if (width < {16'd0, cfg.sweep_limit})
                evt.cls = osd_pkg::CLASS_SWEEP;
            else if (width < {16'd0, cfg.skip_limit})
                evt.cls = osd_pkg::CLASS_SYNC;
            else
                evt.cls = osd_pkg::CLASS_SKIP;
        end
        if (width > osd_pkg::BAND_LOW && width < osd_pkg::BAND_1)
        begin
            evt.axis_val = 1'b1;
            evt.counted  = 1'b1;
        end
        else if (width >= osd_pkg::BAND_1 && width < osd_pkg::BAND_2)
        begin
            evt.axis_val = 1'b0;
            evt.counted  = 1'b1;
        end
        else if (width >= osd_pkg::BAND_2 && width < osd_pkg::BAND_3)
        begin
            evt.axis_val = 1'b1;
            evt.counted  = 1'b1;
        end
        else if (width >= osd_pkg::BAND_3 && width < osd_pkg::BAND_4)
        begin
            evt.axis_val = 1'b0;
            evt.counted  = 1'b1;
        end
        else if (width >= osd_pkg::BAND_4 && width < osd_pkg::BAND_5)
            evt.axis_val = 1'b1;
        else if (width >= osd_pkg::BAND_5 && width < osd_pkg::BAND_6)
            evt.axis_val = 1'b0;
        else if (width >= osd_pkg::BAND_6 && width < osd_pkg::BAND_7)
            evt.axis_val = 1'b1;
        else if (width >= osd_pkg::BAND_7 && width < osd_pkg::BAND_8)
            evt.axis_val = 1'b0;
        else
            evt.axis_hit = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b0;
            pulse_open_reg  <= 1'b0;
            pulse_start_reg <= 32'd0;
        end
        else
        begin
            prev_level_reg  <= prev_level_next;
            pulse_open_reg  <= pulse_open_next;
            pulse_start_reg <= pulse_start_next;
        end
    end

endmodule

FILE: hdl/osd_fifo.sv
module osd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  osd_pkg::evt_t      push_data,
    input  logic               pop,
    output osd_pkg::evt_t      head,
    output osd_pkg::q_stat_t   stat
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    osd_pkg::evt_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign stat.full  = (count_reg == FULLC);
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (!push && pop)
            count_next = count_reg - CW'(1);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
    end

endmodule

FILE: hdl/osd_back.sv
module osd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop,
    input  osd_pkg::evt_t     evt,
    input  osd_pkg::cfg_t     cfg,
    input  logic              result_stall,
    output logic              result_valid,
    output osd_pkg::result_t  result
);

    logic [31:0] ref_start_reg;
    logic [31:0] ref_start_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic        axis_reg;
    logic        axis_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [31:0] batch_start_reg;
    logic [31:0] batch_start_next;
    logic [31:0] angle_reg [4];
    logic [31:0] angle_next [4];
    logic [31:0] span_reg;
    logic [31:0] span_next;
    logic [31:0] total_reg;
    logic [31:0] total_next;
    logic        trig;
    logic [31:0] delay;
    logic        out_valid_reg;
    osd_pkg::result_t out_reg;

    assign delay        = evt.start - ref_start_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // execute one classified event
    always_comb
    begin
        ref_start_next   = ref_start_reg;
        phase_next       = phase_reg;
        pending_next     = pending_reg;
        axis_next        = axis_reg;
        count_next       = count_reg;
        batch_start_next = batch_start_reg;
        angle_next       = angle_reg;
        span_next        = span_reg;
        total_next       = total_reg;
        trig             = 1'b0;
        if (evt.done)
        begin
            case (evt.cls)
                osd_pkg::CLASS_SYNC:
                begin
                    ref_start_next = evt.start;
                    if (phase_reg != osd_pkg::PHASE_NONE)
                    begin
                        if (evt.axis_hit)
                            axis_next = evt.axis_val;
                        if (evt.counted)
                            count_next = count_reg + 8'd1;
                    end
                    if (phase_reg == osd_pkg::PHASE_A || phase_reg == osd_pkg::PHASE_B)
                        pending_next = phase_reg;
                    if (count_next == 8'd1)
                        batch_start_next = evt.start;
                    if (count_next == cfg.sync_batch && cfg.cal_enable)
                    begin
                        count_next = 8'd0;
                        span_next  = evt.start - batch_start_next;
                        total_next = total_reg + 32'd1;
                        trig       = 1'b1;
                    end
                end
                osd_pkg::CLASS_SWEEP:
                begin
                    phase_next = osd_pkg::PHASE_A;
                    if (pending_reg == osd_pkg::PHASE_A)
                    begin
                        if (axis_reg)
                            angle_next[0] = delay;
                        else
                            angle_next[1] = delay;
                        pending_next = osd_pkg::PHASE_NONE;
                    end
                    else if (pending_reg == osd_pkg::PHASE_B)
                    begin
                        if (axis_reg)
                            angle_next[2] = delay;
                        else
                            angle_next[3] = delay;
                        pending_next = osd_pkg::PHASE_NONE;
                    end
                end
                osd_pkg::CLASS_SKIP:
                begin
                    if (phase_reg == osd_pkg::PHASE_A)
                        phase_next = osd_pkg::PHASE_B;
                end
                default:
                begin
                end
            endcase
        end
    end

    // decoder state, advanced once per popped event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_start_reg   <= 32'd0;
            phase_reg       <= osd_pkg::PHASE_NONE;
            pending_reg     <= osd_pkg::PHASE_NONE;
            axis_reg        <= 1'b0;
            count_reg       <= 8'd0;
            batch_start_reg <= 32'd0;
            angle_reg       <= '{default: 32'd0};
            span_reg        <= 32'd0;
            total_reg       <= 32'd0;
        end
        else if (pop)
        begin
            ref_start_reg   <= ref_start_next;
            phase_reg       <= phase_next;
            pending_reg     <= pending_next;
            axis_reg        <= axis_next;
            count_reg       <= count_next;
            batch_start_reg <= batch_start_next;
            angle_reg       <= angle_next;
            span_reg        <= span_next;
            total_reg       <= total_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.pulse_done  <= evt.done;
            out_reg.pulse_class <= evt.cls;
            out_reg.axis_is_x   <= axis_next;
            out_reg.station_a_x <= angle_next[0];
            out_reg.station_a_y <= angle_next[1];
            out_reg.station_b_x <= angle_next[2];
            out_reg.station_b_y <= angle_next[3];
            out_reg.cal_trigger <= trig;
            out_reg.batch_span  <= span_next;
            out_reg.cal_total   <= total_next;
        end
    end

endmodule

FILE: hdl/optical_sync_sweep_pulse_decoder_top.sv
// path: a sample's event is written into the event queue and, once popped, into the output
// register; each event waiting ahead of it in the queue delays its result further
// throughput: one sample per cycle while the event queue, which absorbs result-side stalls,
// is not full; the front classifies and the back runs one event per cycle if not stalled
// reset: asynchronous active low; clears pulse and station state, angles, counters and
// the queue, and loads the configuration defaults
module optical_sync_sweep_pulse_decoder_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  osd_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output osd_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    osd_pkg::cfg_t    cfg_reg;
    osd_pkg::evt_t    front_evt;
    osd_pkg::evt_t    q_head;
    osd_pkg::q_stat_t q_stat;
    logic             accept;
    logic             pop;

    assign cfg_ready    = 1'b1;
    assign sample_stall = q_stat.full;
    assign accept       = sample_valid && !q_stat.full;
    assign pop          = !q_stat.empty && (!result_valid || !result_stall);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_enable  <= 1'b0;
            cfg_reg.sweep_limit <= osd_pkg::SWEEP_LIMIT_RST;
            cfg_reg.skip_limit  <= osd_pkg::SKIP_LIMIT_RST;
            cfg_reg.sync_batch  <= osd_pkg::SYNC_BATCH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                osd_pkg::REG_CAL_ENABLE:  cfg_reg.cal_enable  <= cfg_data[0];
                osd_pkg::REG_SWEEP_LIMIT: cfg_reg.sweep_limit <= cfg_data;
                osd_pkg::REG_SKIP_LIMIT:  cfg_reg.skip_limit  <= cfg_data;
                osd_pkg::REG_SYNC_BATCH:  cfg_reg.sync_batch  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // edge detection and classification
    osd_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .evt    (front_evt)
    );

    // event queue
    osd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_evt),
        .pop       (pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // station and calibration bookkeeping
    osd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .evt          (q_head),
        .cfg          (cfg_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // a calibration trigger only comes from a closed sync pulse
    a_trig_sync: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.cal_trigger |->
            result.pulse_done && result.pulse_class == osd_pkg::CLASS_SYNC)
        else $error("calibration trigger without sync pulse");

    // no class without a closed pulse
    a_class_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.pulse_done |-> result.pulse_class == osd_pkg::CLASS_SWEEP)
        else $error("pulse class set without closed pulse");

    // the queue is never full and empty at once
    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_stat.empty)
        else $error("queue status inconsistent");

    // trigger total holds across popped events that close no pulse
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop && $past(pop) && !q_head.done |=> result.cal_total == $past(result.cal_total))
        else $error("trigger total moved without a pulse");

endmodule

FILE: test/tb_optical_sync_sweep_pulse_decoder_top.sv
`timescale 1ns / 100ps

module tb_optical_sync_sweep_pulse_decoder_top;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 255;
    localparam int NUM_SETTINGS = 7;

    // one row of the directed stimulus table
    typedef struct {
        logic        light;
        logic [31:0] tick;
        bit          known;
        logic        done;
        logic [1:0]  cls;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_stall;
    osd_pkg::sample_t   sample;
    logic               result_valid;
    logic               result_stall = 1'b0;
    osd_pkg::result_t   result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [15:0]        cfg_data;

    // decoder image: configuration
    logic        cal_en     = 1'b0;
    logic [15:0] sweep_lim  = osd_pkg::SWEEP_LIMIT_RST;
    logic [15:0] skip_lim   = osd_pkg::SKIP_LIMIT_RST;
    logic [7:0]  batch_len  = osd_pkg::SYNC_BATCH_RST;

    // decoder image: pulse and station state
    logic        last_light    = 1'b0;
    logic        in_pulse      = 1'b0;
    logic [31:0] rise_tick     = '0;
    logic [31:0] ref_tick      = '0;
    logic [1:0]  station_ph    = osd_pkg::PHASE_NONE;
    logic [1:0]  target_station = osd_pkg::PHASE_NONE;
    logic        axis_x        = 1'b0;
    logic [7:0]  sync_cnt      = '0;
    logic [31:0] batch_first   = '0;
    logic [31:0] angle_ax      = '0;
    logic [31:0] angle_ay      = '0;
    logic [31:0] angle_bx      = '0;
    logic [31:0] angle_by      = '0;
    logic [31:0] span_ticks    = '0;
    logic [31:0] trigger_cnt   = '0;

    osd_pkg::result_t awaited_results[$];
    dir_row_t         dir_rows[$];

    int  errors        = 0;
    int  samples_sent  = 0;
    int  pulses_seen   = 0;
    int  triggers_seen = 0;
    int  settings_used = 0;
    int  quiet_cycles  = 0;
    bit  steady        = 1'b0;

    optical_sync_sweep_pulse_decoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // predict the result of one sample and advance the decoder image
    task automatic decode_sample(input osd_pkg::sample_t s, output osd_pkg::result_t r);
        logic [31:0] w;
        logic [31:0] delay;
        logic        counted;
        r = '0;
        if (!last_light && s.light_level)
        begin
            if (!in_pulse)
            begin
                rise_tick = s.tick_time;
                in_pulse  = 1'b1;
            end
        end
        else if (last_light && !s.light_level && in_pulse)
        begin
            w = s.tick_time - rise_tick;
            in_pulse = 1'b0;
            r.pulse_done = 1'b1;
            if (w < {16'd0, sweep_lim})
                r.pulse_class = osd_pkg::CLASS_SWEEP;
            else if (w < {16'd0, skip_lim})
                r.pulse_class = osd_pkg::CLASS_SYNC;
            else
                r.pulse_class = osd_pkg::CLASS_SKIP;

            case (r.pulse_class)
                osd_pkg::CLASS_SYNC:
                begin
                    ref_tick = rise_tick;
                    // axis bands, only the lower four count towards a batch
                    if (station_ph != osd_pkg::PHASE_NONE)
                    begin
                        counted = (w > osd_pkg::BAND_LOW) && (w < osd_pkg::BAND_4);
                        if (w > osd_pkg::BAND_LOW && w < osd_pkg::BAND_1)
                            axis_x = 1'b1;
                        else if (w >= osd_pkg::BAND_1 && w < osd_pkg::BAND_2)
                            axis_x = 1'b0;
                        else if (w >= osd_pkg::BAND_2 && w < osd_pkg::BAND_3)
                            axis_x = 1'b1;
                        else if (w >= osd_pkg::BAND_3 && w < osd_pkg::BAND_4)
                            axis_x = 1'b0;
                        else if (w >= osd_pkg::BAND_4 && w < osd_pkg::BAND_5)
                            axis_x = 1'b1;
                        else if (w >= osd_pkg::BAND_5 && w < osd_pkg::BAND_6)
                            axis_x = 1'b0;
                        else if (w >= osd_pkg::BAND_6 && w < osd_pkg::BAND_7)
                            axis_x = 1'b1;
                        else if (w >= osd_pkg::BAND_7 && w < osd_pkg::BAND_8)
                            axis_x = 1'b0;
                        if (counted)
                            sync_cnt = sync_cnt + 8'd1;
                    end
                    if (station_ph == osd_pkg::PHASE_A || station_ph == osd_pkg::PHASE_B)
                        target_station = station_ph;
                    if (sync_cnt == 8'd1)
                        batch_first = rise_tick;
                    // batch end
                    if (sync_cnt == batch_len && cal_en)
                    begin
                        sync_cnt      = '0;
                        span_ticks    = rise_tick - batch_first;
                        trigger_cnt   = trigger_cnt + 32'd1;
                        r.cal_trigger = 1'b1;
                    end
                end
                osd_pkg::CLASS_SWEEP:
                begin
                    delay = rise_tick - ref_tick;
                    station_ph = osd_pkg::PHASE_A;
                    if (target_station == osd_pkg::PHASE_A)
                    begin
                        if (axis_x) angle_ax = delay;
                        else        angle_ay = delay;
                        target_station = osd_pkg::PHASE_NONE;
                    end
                    else if (target_station == osd_pkg::PHASE_B)
                    begin
                        if (axis_x) angle_bx = delay;
                        else        angle_by = delay;
                        target_station = osd_pkg::PHASE_NONE;
                    end
                end
                default:
                begin
                    if (station_ph == osd_pkg::PHASE_A)
                        station_ph = osd_pkg::PHASE_B;
                end
            endcase
        end
        last_light    = s.light_level;
        r.axis_is_x   = axis_x;
        r.station_a_x = angle_ax;
        r.station_a_y = angle_ay;
        r.station_b_x = angle_bx;
        r.station_b_y = angle_by;
        r.batch_span  = span_ticks;
        r.cal_total   = trigger_cnt;
    endtask

    // one line per mismatch, every mismatch counted
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // present one sample transaction and record its expected result
    task automatic send_sample(input logic light, input logic [31:0] tick, input bit known,
                               input osd_pkg::result_t want);
        osd_pkg::result_t predicted;
        if (!steady)
        begin
            while ($urandom_range(99) < 36)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample       <= {light, tick};
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        decode_sample({light, tick}, predicted);
        awaited_results.push_back(known ? want : predicted);
        samples_sent++;
    endtask

    // write all four registers once the decoder has drained
    task automatic write_config(input osd_pkg::cfg_t c);
        logic [15:0] vals [4];
        logic [7:0]  regs [4];
        vals[0] = {15'd0, c.cal_enable};
        vals[1] = c.sweep_limit;
        vals[2] = c.skip_limit;
        vals[3] = {8'd0, c.sync_batch};
        regs[0] = osd_pkg::REG_CAL_ENABLE;
        regs[1] = osd_pkg::REG_SWEEP_LIMIT;
        regs[2] = osd_pkg::REG_SKIP_LIMIT;
        regs[3] = osd_pkg::REG_SYNC_BATCH;
        sample_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cal_en    = c.cal_enable;
        sweep_lim = c.sweep_limit;
        skip_lim  = c.skip_limit;
        batch_len = c.sync_batch;
        settings_used++;
    endtask

    // pulse width biased towards the class limits and axis bands
    function automatic logic [31:0] pick_width();
        logic [31:0] e;
        int          r;
        r = $urandom_range(99);
        if (r < 28)
            return (sweep_lim == 16'd0) ? $urandom_range(499) : $urandom_range(sweep_lim - 1);
        if (r < 63)
            return $urandom_range(988, 501);
        if (r < 73)
            return $urandom_range(1399, 989);
        if (r < 83)
            return {16'd0, skip_lim} + $urandom_range(3000);
        if (r < 95)
        begin
            case ($urandom_range(9))
                0: e = osd_pkg::BAND_LOW;
                1: e = osd_pkg::BAND_1;
                2: e = osd_pkg::BAND_2;
                3: e = osd_pkg::BAND_3;
                4: e = osd_pkg::BAND_4;
                5: e = osd_pkg::BAND_5;
                6: e = osd_pkg::BAND_6;
                7: e = osd_pkg::BAND_7;
                8: e = osd_pkg::BAND_8;
                default: e = $urandom_range(1) ? {16'd0, sweep_lim} : {16'd0, skip_lim};
            endcase
            return e - $urandom_range(1);
        end
        return $urandom();
    endfunction

    // mostly well-formed pulses with random widths, some stray samples
    task automatic run_random(input int count);
        logic [31:0] t;
        logic [31:0] w;
        int          target;
        target = samples_sent + count;
        t = $urandom();
        while (samples_sent < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                w = pick_width();
                if ($urandom_range(15) == 0)
                    t = $urandom();
                send_sample(1'b1, t, 1'b0, '0);
                repeat ($urandom_range(2))
                    send_sample(1'b1, $urandom(), 1'b0, '0);
                send_sample(1'b0, t + w, 1'b0, '0);
                repeat ($urandom_range(2))
                    send_sample(1'b0, $urandom(), 1'b0, '0);
                t = t + w + $urandom_range(5000);
            end
            else
                send_sample($urandom_range(1), $urandom(), 1'b0, '0);
        end
    endtask

    task automatic add_row(input logic light, input logic [31:0] tick, input bit known,
                           input logic done, input logic [1:0] cls);
        dir_row_t row;
        row.light = light;
        row.tick  = tick;
        row.known = known;
        row.done  = done;
        row.cls   = cls;
        dir_rows.push_back(row);
    endtask

    // result side: random stall outside the steady setting, check each transaction in order
    always @(posedge clk)
    begin : result_side
        osd_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with none outstanding", result.cal_total, 32'd0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.pulse_done)  pulses_seen++;
                    if (want.cal_trigger) triggers_seen++;
                    check_field("pulse_done",  32'(result.pulse_done),  32'(want.pulse_done));
                    check_field("pulse_class", 32'(result.pulse_class), 32'(want.pulse_class));
                    check_field("axis_is_x",   32'(result.axis_is_x),   32'(want.axis_is_x));
                    check_field("station_a_x", result.station_a_x, want.station_a_x);
                    check_field("station_a_y", result.station_a_y, want.station_a_y);
                    check_field("station_b_x", result.station_b_x, want.station_b_x);
                    check_field("station_b_y", result.station_b_y, want.station_b_y);
                    check_field("cal_trigger", 32'(result.cal_trigger), 32'(want.cal_trigger));
                    check_field("batch_span",  result.batch_span,  want.batch_span);
                    check_field("cal_total",   result.cal_total,   want.cal_total);
                end
            end
            result_stall <= steady ? 1'b0 : ($urandom_range(99) < 36);
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        osd_pkg::cfg_t    plan [NUM_SETTINGS];
        osd_pkg::result_t want;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = osd_pkg::REG_CAL_ENABLE;
        cfg_data     = '0;

        // settings walked after the directed part, extremes included
        plan[0] = {1'b1, 16'd500,   16'd990,   8'd3};
        plan[1] = {1'b1, 16'd0,     16'd65535, 8'd1};
        plan[2] = {1'b0, 16'd65535, 16'd0,     8'd255};
        plan[3] = {1'b1, 16'd300,   16'd1500,  8'd255};
        plan[4] = {1'b1, 16'd500,   16'd990,   8'd0};
        plan[5].cal_enable  = 1'b1;
        plan[5].sweep_limit = 16'($urandom_range(1200));
        plan[5].skip_limit  = plan[5].sweep_limit + 16'($urandom_range(1200));
        plan[5].sync_batch  = 8'($urandom_range(8, 1));
        plan[6] = {1'b0, osd_pkg::SWEEP_LIMIT_RST, osd_pkg::SKIP_LIMIT_RST,
                   osd_pkg::SYNC_BATCH_RST};

        // directed table, reset defaults in force
        add_row(1'b0, 32'd0,        1'b1, 1'b0, osd_pkg::CLASS_SWEEP);  // idle sample after reset
        add_row(1'b1, 32'd100,      1'b1, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd700,      1'b1, 1'b1, osd_pkg::CLASS_SYNC);   // sync with no station phase
        add_row(1'b1, 32'd1000,     1'b1, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd1010,     1'b1, 1'b1, osd_pkg::CLASS_SWEEP);  // sweep with nothing pending
        add_row(1'b1, 32'd2000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd2600,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // counted x sync, batch start
        add_row(1'b1, 32'd3000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd3005,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // station a x angle
        add_row(1'b1, 32'd4000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd5000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // skip moves to station b
        add_row(1'b1, 32'd6000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd6700,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // counted y sync
        add_row(1'b1, 32'd7000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd7001,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // station b y angle
        add_row(1'b1, 32'd8000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd8500,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // sync on the lower band edge
        add_row(1'b1, 32'd9000,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd9499,     1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // widest sweep
        add_row(1'b1, 32'd10000,    1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'd10989,    1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // widest sync, uncounted band
        add_row(1'b1, 32'hFFFFFF00, 1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'h00000200, 1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // width across the timer wrap
        add_row(1'b1, 32'hFFFFFFFF, 1'b0, 1'b0, osd_pkg::CLASS_SWEEP);
        add_row(1'b0, 32'hFFFFFFFF, 1'b0, 1'b0, osd_pkg::CLASS_SWEEP);  // zero width, top tick

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            want = '0;
            want.pulse_done  = dir_rows[i].done;
            want.pulse_class = dir_rows[i].cls;
            send_sample(dir_rows[i].light, dir_rows[i].tick, dir_rows[i].known, want);
        end

        // random part, one setting at a time, second one with no idling
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            write_config(plan[p]);
            steady = (p == 1);
            run_random(PHASE_ITEMS);
        end
        steady = 1'b0;

        // drain and let the pipeline settle
        sample_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d samples over %0d settings: %0d pulses closed, %0d triggers",
                 samples_sent, settings_used, pulses_seen, triggers_seen);
        $display("%0d field mismatches found", errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hdl/osd_pkg.sv
hdl/osd_front.sv
hdl/osd_fifo.sv
hdl/osd_back.sv
hdl/optical_sync_sweep_pulse_decoder_top.sv
test/tb_optical_sync_sweep_pulse_decoder_top.sv
